@@ sv/mamm_pkg.sv @@
// ----------------------------------------------------------------------------
// mamm_pkg
// Shared constants and types for the moving average min/max tracker.
// ----------------------------------------------------------------------------
package mamm_pkg;

	// window length, a power of two so the average is a shift
	localparam int WIN_LOG2 = 3;
	localparam int WIN_LEN  = 1 << WIN_LOG2;

	// sample and running sum widths
	localparam int SMP_W = 16;
	localparam int SUM_W = SMP_W + WIN_LOG2;

	// request kinds
	localparam logic [1:0] KIND_SAMPLE  = 2'd0;
	localparam logic [1:0] KIND_RST_MIN = 2'd1;
	localparam logic [1:0] KIND_RST_MAX = 2'd2;

	// average handed from the window to the tracker
	typedef struct packed {
		logic                    first;
		logic signed [SMP_W-1:0] avg;
	} avg_t;

endpackage

@@ sv/mamm_window.sv @@
// ----------------------------------------------------------------------------
// mamm_window
// Sample window with running sum; gives the truncated average of the window
// as it stands once the presented sample is taken in.
// ----------------------------------------------------------------------------
module mamm_window
	import mamm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sample_en,
	input  logic signed [SMP_W-1:0] sample,
	output avg_t                    avg_info
);

	logic signed [SMP_W-1:0] window_q [WIN_LEN];
	logic signed [SUM_W-1:0] sum_q;
	logic [WIN_LOG2-1:0]     pos_q;
	logic                    first_q;

	logic signed [SUM_W-1:0] smp_ext;
	logic signed [SUM_W-1:0] base_sum;
	logic signed [SUM_W-1:0] old_ext;
	logic signed [SUM_W-1:0] new_sum;
	logic signed [SUM_W-1:0] adj_sum;
	logic signed [SUM_W-1:0] shf_sum;

	// running sum update; first sample fills the whole window
	always_comb begin
		smp_ext  = SUM_W'(sample);
		base_sum = first_q ? (smp_ext <<< WIN_LOG2) : sum_q;
		old_ext  = first_q ? smp_ext : SUM_W'(window_q[pos_q]);
		new_sum  = base_sum - old_ext + smp_ext;
	end

	// divide by window length, truncating toward zero
	always_comb begin
		adj_sum = new_sum[SUM_W-1] ? (new_sum + SUM_W'(WIN_LEN - 1)) : new_sum;
		shf_sum = adj_sum >>> WIN_LOG2;
		avg_info.avg   = shf_sum[SMP_W-1:0];
		avg_info.first = first_q;
	end

	// window storage
	always_ff @(posedge clk) begin
		if (sample_en) begin
			for (int i = 0; i < WIN_LEN; i++) begin
				if (first_q || pos_q == WIN_LOG2'(i)) begin
					window_q[i] <= sample;
				end
			end
		end
	end

	// sum, write position and first flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			pos_q   <= '0;
			first_q <= 1'b1;
		end else if (sample_en) begin
			sum_q   <= new_sum;
			pos_q   <= (pos_q == WIN_LOG2'(WIN_LEN - 1)) ? '0 : pos_q + 1'b1;
			first_q <= 1'b0;
		end
	end

endmodule

@@ sv/mamm_track.sv @@
// ----------------------------------------------------------------------------
// mamm_track
// Current, minimum and maximum average registers, updated per request.
// ----------------------------------------------------------------------------
module mamm_track
	import mamm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic [1:0]              kind,
	input  avg_t                    avg_info,
	output logic signed [SMP_W-1:0] cur_q,
	output logic signed [SMP_W-1:0] min_q,
	output logic signed [SMP_W-1:0] max_q
);

	logic signed [SMP_W-1:0] cur_d;
	logic signed [SMP_W-1:0] min_d;
	logic signed [SMP_W-1:0] max_d;

	// next values per request kind
	always_comb begin
		cur_d = cur_q;
		min_d = min_q;
		max_d = max_q;
		case (kind)
			KIND_SAMPLE: begin
				cur_d = avg_info.avg;
				if (avg_info.first || min_q > avg_info.avg) begin
					min_d = avg_info.avg;
				end
				if (avg_info.first || max_q < avg_info.avg) begin
					max_d = avg_info.avg;
				end
			end
			KIND_RST_MIN: begin
				min_d = cur_q;
			end
			KIND_RST_MAX: begin
				max_d = cur_q;
			end
			default: begin
				cur_d = cur_q;
			end
		endcase
	end

	// result registers double as tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			min_q <= '0;
			max_q <= '0;
		end else if (en) begin
			cur_q <= cur_d;
			min_q <= min_d;
			max_q <= max_d;
		end
	end

endmodule

@@ sv/moving_average_min_max_tracker.sv @@
// ----------------------------------------------------------------------------
// moving_average_min_max_tracker
// Boxcar moving average of signed samples with min/max tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on the s_axis group: s_tuser carries the kind (sample,
//   reset minimum, reset maximum), s_tdata the signed 16-bit sample.
//   Every request yields one result on the m_axis group: current average,
//   minimum and maximum, packed in m_tdata from the low bits up.
//   A request is registered in an input stage, processed by one level of
//   logic (running sum, shift, compares) and lands in the result register,
//   which also holds the tracker state. m_tvalid rises as the request
//   moves from the input stage into the result register; one request per
//   cycle is sustained while m_tready stays high.
//   The running sum of the eight-entry window swaps the oldest sample for the new one.
//   When the receiver stalls, the result holds, the input stage keeps one
//   more request, and s_tready drops until the result is taken.
//   Reset clears all handshake state and the averages to zero; the first
//   sample afterwards fills the whole window and sets minimum and maximum.
// ----------------------------------------------------------------------------
module moving_average_min_max_tracker
	import mamm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // [15:0] current_avg, [31:16] min_avg, [47:32] max_avg
);

	logic                    valid_s1;
	logic [1:0]              kind_s1;
	logic signed [SMP_W-1:0] sample_s1;
	logic                    out_valid_q;
	logic                    advance;
	logic                    s_accept;
	logic                    sample_en;
	avg_t                    avg_info;
	logic signed [SMP_W-1:0] cur_q;
	logic signed [SMP_W-1:0] min_q;
	logic signed [SMP_W-1:0] max_q;

	// handshake control
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign s_accept  = s_tvalid && s_tready;
	assign sample_en = advance && (kind_s1 == KIND_SAMPLE);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			kind_s1   <= s_tuser;
			sample_s1 <= s_tdata;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// window and running sum
	mamm_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_en (sample_en),
		.sample    (sample_s1),
		.avg_info  (avg_info)
	);

	// current, min and max
	mamm_track u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.kind     (kind_s1),
		.avg_info (avg_info),
		.cur_q    (cur_q),
		.min_q    (min_q),
		.max_q    (max_q)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {max_q, min_q, cur_q};

`ifndef SYNTH
	// current average always lies between the tracked extremes
	a_cur_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (min_q <= cur_q) && (cur_q <= max_q))
		else $error("current average outside min/max");

	// a processed request always shows up as a result
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed request produced no result");

	// extreme resets and the unused kind leave the current average alone
	a_cmd_keeps_cur: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (kind_s1 != KIND_SAMPLE) |=> $stable(cur_q))
		else $error("command changed current average");

	// held input stage keeps its request
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(kind_s1) && $stable(sample_s1))
		else $error("input stage lost a request");
`endif

endmodule

@@ dv/tb_moving_average_min_max_tracker.sv @@
// ----------------------------------------------------------------------------
// tb_moving_average_min_max_tracker
// Self-checking bench for the boxcar moving average with min/max tracking.
// ----------------------------------------------------------------------------
// A directed opening covers extreme samples, every request kind, extreme
// resets before the first sample, the unused kind and rounding of negative
// sums toward zero. Random phases follow with random gaps on both sides,
// long receiver stalls that back up the input, and drains in between.
// An in-bench predictor tracks the window, running sum and extremes and
// checks every result field by field in order.
// ----------------------------------------------------------------------------
module tb_moving_average_min_max_tracker;
	timeunit 1ns;
	timeprecision 1ps;

	import mamm_pkg::*;

	// kind value with no meaning, the block must ignore it
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_REQUESTS = 1250;
	localparam int PHASES          = 5;
	localparam int IDLE_LIMIT      = 3000;
	localparam int LONG_HOLD       = 150;

	typedef struct {
		logic signed [SMP_W-1:0] current_avg;
		logic signed [SMP_W-1:0] min_avg;
		logic signed [SMP_W-1:0] max_avg;
	} avg_result_t;

	// predicts the averages and holds them until the block returns them
	class avg_tracker_scoreboard;
		logic signed [SMP_W-1:0] samples [WIN_LEN];
		int                      running_sum;
		int                      wr_pos;
		bit                      awaiting_first;
		logic signed [SMP_W-1:0] cur_avg, lo_avg, hi_avg;
		avg_result_t             expected_averages [$];
		int                      mismatches;

		function new();
			foreach (samples[i])
				samples[i] = '0;
			running_sum    = 0;
			wr_pos         = 0;
			awaiting_first = 1'b1;
			cur_avg        = '0;
			lo_avg         = '0;
			hi_avg         = '0;
			mismatches     = 0;
		endfunction

		function int pending();
			return expected_averages.size();
		endfunction

		// apply one accepted request to the predicted state
		function void note_request(logic [1:0] kind, logic signed [SMP_W-1:0] smp);
			avg_result_t r;
			int          quot;
			case (kind)
				KIND_SAMPLE: begin
					// first sample fills the whole window
					if (awaiting_first) begin
						foreach (samples[i])
							samples[i] = smp;
						running_sum = smp * WIN_LEN;
					end
					running_sum     = running_sum - samples[wr_pos] + smp;
					samples[wr_pos] = smp;
					wr_pos          = (wr_pos + 1) % WIN_LEN;
					// int division truncates toward zero
					quot    = running_sum / WIN_LEN;
					cur_avg = quot[SMP_W-1:0];
					if (awaiting_first) begin
						lo_avg = cur_avg;
						hi_avg = cur_avg;
					end
					if (lo_avg > cur_avg)
						lo_avg = cur_avg;
					if (hi_avg < cur_avg)
						hi_avg = cur_avg;
					awaiting_first = 1'b0;
				end
				KIND_RST_MIN: lo_avg = cur_avg;
				KIND_RST_MAX: hi_avg = cur_avg;
				default: ;
			endcase
			r.current_avg = cur_avg;
			r.min_avg     = lo_avg;
			r.max_avg     = hi_avg;
			expected_averages.push_back(r);
		endfunction

		// compare one returned result with the oldest prediction
		function void check_result(logic [3*SMP_W-1:0] data);
			avg_result_t e;
			logic signed [SMP_W-1:0] got_cur, got_min, got_max;
			got_cur = data[SMP_W-1:0];
			got_min = data[2*SMP_W-1:SMP_W];
			got_max = data[3*SMP_W-1:2*SMP_W];
			if (expected_averages.size() == 0) begin
				$display("%0t: unexpected result cur=%0d min=%0d max=%0d",
					$time, got_cur, got_min, got_max);
				mismatches++;
				return;
			end
			e = expected_averages.pop_front();
			if (got_cur !== e.current_avg) begin
				$display("%0t: current_avg expected %0d actual %0d",
					$time, e.current_avg, got_cur);
				mismatches++;
			end
			if (got_min !== e.min_avg) begin
				$display("%0t: min_avg expected %0d actual %0d",
					$time, e.min_avg, got_min);
				mismatches++;
			end
			if (got_max !== e.max_avg) begin
				$display("%0t: max_avg expected %0d actual %0d",
					$time, e.max_avg, got_max);
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [SMP_W-1:0]     s_tdata;
	logic [1:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [3*SMP_W-1:0]   m_tdata;

	avg_tracker_scoreboard sb = new();
	bit sender_gappy;
	bit receiver_gappy;
	int results_taken;
	int idle_cycles;

	moving_average_min_max_tracker u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock, 12 ns period
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// random wait before a request or a result, zero in quiet stretches
	function automatic int draw_gap(bit gappy);
		return gappy ? $urandom_range(0, 19) : 0;
	endfunction

	// mix of full range, near zero and near the extremes
	function automatic logic [SMP_W-1:0] draw_sample();
		int v;
		case ($urandom_range(0, 3))
			0: v = $urandom_range(0, 15) - 8;
			1: v = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 3)
				: -32768 + $urandom_range(0, 3);
			default: v = $urandom_range(0, 65535);
		endcase
		return v[SMP_W-1:0];
	endfunction

	function automatic logic [1:0] draw_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return KIND_SAMPLE;
		else if (r < 89)
			return KIND_RST_MIN;
		else if (r < 98)
			return KIND_RST_MAX;
		return KIND_UNUSED;
	endfunction

	// offer one request and wait until it is accepted
	task automatic send_request(logic [1:0] kind, logic [SMP_W-1:0] smp);
		int gap;
		gap = draw_gap(sender_gappy);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= smp;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(kind, smp);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// result side: random ready gaps, plus long stalls that back up the input
	initial begin
		int gap;
		m_tready = 1'b0;
		receiver_gappy = 1'b1;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 39) == 0)
				receiver_gappy = !receiver_gappy;
			gap = draw_gap(receiver_gappy);
			if (results_taken == 300 || results_taken == 900)
				gap += LONG_HOLD;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata);
			results_taken <= results_taken + 1;
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// reset, directed opening, random phases, end of run
	initial begin
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = KIND_SAMPLE;
		arst_n        = 1'b0;
		sender_gappy  = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// extreme resets and the unused kind before any sample
		send_request(KIND_RST_MIN, 16'h0000);
		send_request(KIND_RST_MAX, 16'hFFFF);
		send_request(KIND_UNUSED, 16'h1234);
		// first sample sets both extremes
		send_request(KIND_SAMPLE, 16'h7FFF);
		repeat (WIN_LEN) send_request(KIND_SAMPLE, 16'h8000);
		send_request(KIND_SAMPLE, 16'h7FFF);
		send_request(KIND_RST_MIN, 16'h0000);
		send_request(KIND_RST_MAX, 16'h0000);
		send_request(KIND_UNUSED, 16'hFFFF);
		// negative sums round toward zero
		repeat (WIN_LEN) send_request(KIND_SAMPLE, 16'h0000);
		send_request(KIND_SAMPLE, 16'hFFFF);
		send_request(KIND_SAMPLE, 16'hFFF9);
		send_request(KIND_SAMPLE, 16'h5555);
		send_request(KIND_SAMPLE, 16'hAAAA);
		drain_results();

		// random phases, alternating gappy and back-to-back requests
		for (int p = 0; p < PHASES; p++) begin
			sender_gappy = p[0];
			for (int i = 0; i < RANDOM_REQUESTS / PHASES; i++)
				send_request(draw_kind(), draw_sample());
			drain_results();
		end

		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
